@@ design/abrff_pkg.sv @@
// shared types and constants of the audio byte ring frame feeder
// no dependencies; imported by the top level and the checker

package abrff_pkg;

   localparam int RING_BYTES = 65536;                 // power of two
   localparam int ADDR_W     = $clog2(RING_BYTES);
   localparam int PTR_W      = ADDR_W + 1;           // pointers count modulo 2*RING_BYTES
   localparam int FILL_W     = 17;
   localparam int CMP_W      = (PTR_W > FILL_W) ? PTR_W : FILL_W;
   localparam int SAMPLE_W   = 16;
   localparam int BYTE_W     = 8;
   localparam int CNT_W      = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = FILL_W;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 56;

   localparam logic [CNT_W-1:0]  STEREO_FRAME_BYTES = CNT_W'(4);
   localparam logic [CNT_W-1:0]  MONO_FRAME_BYTES   = CNT_W'(2);
   localparam logic [FILL_W-1:0] REFILL_BELOW_RESET = FILL_W'(32768);

   localparam logic [CSR_IDX_W-1:0] CSR_STEREO_MODE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REFILL_BELOW = 1'b1;

   typedef enum logic [1:0] {
      FUNC_PUSH        = 2'd0,
      FUNC_PULL        = 2'd1,
      FUNC_REFILL_DONE = 2'd2,
      FUNC_RESTART     = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PULL,
      ST_FIN,
      ST_DONE
   } state_type;

   // one result beat, msb first
   typedef struct packed {
      logic [FILL_W-1:0]   fill_level;
      logic                refill_request;
      logic                overflow;
      logic                underrun;
      logic                frame_valid;
      logic [SAMPLE_W-1:0] right_sample;
      logic [SAMPLE_W-1:0] left_sample;
   } result_type;

   localparam int RESULT_W = $bits(result_type);

endpackage

@@ design/abrff_ram.sv @@
// generic single-clock ram, one write port and one registered read port
// no dependencies

module abrff_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wen,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wen) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ design/audio_byte_ring_frame_feeder.sv @@
// top level of the audio byte ring frame feeder: pointers, control sequencer, result register
// depends on abrff_pkg and abrff_ram

// Byte ring buffer that feeds 16-bit little-endian PCM frames to an audio
// output. Every request beat gives exactly one response beat. func (tuser)
// selects: push one byte, pull one left/right frame, refill done, restart.
// The ring data lives in one byte-wide synchronous ram; the pointers,
// the refill flag and the two configuration registers are flip-flops. A
// push, refill done or restart goes through ST_DONE, which loads the
// response register once the output register is free and returns to idle.
// A pull reads its bytes one per cycle through the single ram read port,
// 4 bytes for a stereo frame and 2 for a mono frame, and answers an
// underrun without reading; its response is loaded as ST_DONE returns to
// idle, ready for the next request. One item is in work at a time;
// a new request is taken while the previous response still waits in the
// output register. Writes to a full ring are dropped and flagged overflow.
// A pull with too few bytes answers silence and flags underrun. After every
// pull the refill request is set while the fill level is below
// refill_below; only refill done or restart clear it. No clearing pass is
// needed after reset: ram bytes are only read after being pushed.
// Configuration writes are expected only while the block is idle.

module audio_byte_ring_frame_feeder
   import abrff_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] data_byte
   input  logic [1:0]            req_tuser,   // [1:0] func
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [15:0] left_sample, [31:16] right_sample, [32] frame_valid,
   // [33] underrun, [34] overflow, [35] refill_request,
   // [52:36] fill_level, [55:53] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // configuration write port
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // control state
   state_type                      state_ff, state_in;
   logic [PTR_W-1:0]               wp_ff, wp_in;
   logic [PTR_W-1:0]               rp_ff, rp_in;
   logic                           flag_ff, flag_in;
   logic [CNT_W-1:0]               idx_ff, idx_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   // configuration
   logic                           stereo_ff;
   logic [FILL_W-1:0]              below_ff;
   // payload
   logic [3:0][BYTE_W-1:0]         bytes_ff, bytes_in;
   result_type                     res_ff, res_in;
   result_type                     rsp_data_ff, rsp_data_in;

   // ram port
   logic                           ram_wen;
   logic [ADDR_W-1:0]              ram_waddr;
   logic [ADDR_W-1:0]              ram_raddr;
   logic [BYTE_W-1:0]              ram_rdata;

   logic [PTR_W-1:0]               fill;
   logic                           full;
   logic                           below;
   logic [CNT_W-1:0]               need;
   logic [1:0]                     slot;
   logic                           req_accept;
   logic                           rsp_free;
   func_type                       func;

   abrff_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RING_BYTES)
   ) u_ring (
      .clock (clock),
      .wen   (ram_wen),
      .waddr (ram_waddr),
      .wdata (req_tdata[BYTE_W-1:0]),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // pointers wrap at twice the ring size, so the difference is the fill level
   assign fill  = wp_ff - rp_ff;
   assign full  = (fill >= PTR_W'(RING_BYTES));
   assign below = (CMP_W'(fill) < CMP_W'(below_ff));
   assign need  = stereo_ff ? STEREO_FRAME_BYTES : MONO_FRAME_BYTES;
   // slot of the byte whose read was issued last cycle
   assign slot  = idx_ff[1:0] - 2'd1;

   assign func       = func_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // the read port always follows the read pointer; its data comes out of the ram's read register
   assign ram_raddr = rp_ff[ADDR_W-1:0];
   assign ram_waddr = wp_ff[ADDR_W-1:0];

   always_comb begin
      state_in    = state_ff;
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      flag_in     = flag_ff;
      idx_in      = idx_ff;
      bytes_in    = bytes_ff;
      res_in      = res_ff;
      rsp_data_in = rsp_data_ff;
      ram_wen     = 1'b0;

      // output register drains independently of the sequencer
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               res_in                = '0;
               res_in.refill_request = flag_ff;
               res_in.fill_level     = FILL_W'(fill);
               state_in              = ST_DONE;
               case (func)
                  FUNC_PUSH: begin
                     if (full) begin
                        // ring full: drop the byte
                        res_in.overflow = 1'b1;
                     end else begin
                        ram_wen           = 1'b1;
                        wp_in             = wp_ff + PTR_W'(1);
                        res_in.fill_level = FILL_W'(fill + PTR_W'(1));
                     end
                  end
                  FUNC_PULL: begin
                     if (PTR_W'(need) <= fill) begin
                        // first byte read issued now
                        rp_in    = rp_ff + PTR_W'(1);
                        idx_in   = CNT_W'(1);
                        state_in = ST_PULL;
                     end else begin
                        // underrun: silence, refill check still runs
                        res_in.underrun       = 1'b1;
                        flag_in               = flag_ff || below;
                        res_in.refill_request = flag_ff || below;
                     end
                  end
                  FUNC_REFILL_DONE: begin
                     flag_in               = 1'b0;
                     res_in.refill_request = 1'b0;
                  end
                  FUNC_RESTART: begin
                     wp_in                 = '0;
                     rp_in                 = '0;
                     flag_in               = 1'b0;
                     res_in.refill_request = 1'b0;
                     res_in.fill_level     = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PULL: begin
            bytes_in[slot] = ram_rdata;
            if (idx_ff < need) begin
               rp_in  = rp_ff + PTR_W'(1);
               idx_in = idx_ff + CNT_W'(1);
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // assemble little-endian samples, mono copies left to right
            res_in.left_sample    = {bytes_ff[1], bytes_ff[0]};
            res_in.right_sample   = stereo_ff ? {bytes_ff[3], bytes_ff[2]}
                                              : {bytes_ff[1], bytes_ff[0]};
            res_in.frame_valid    = 1'b1;
            res_in.fill_level     = FILL_W'(fill);
            flag_in               = flag_ff || below;
            res_in.refill_request = flag_ff || below;
            state_in              = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         flag_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         flag_ff      <= flag_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stereo_ff <= 1'b0;
         below_ff  <= REFILL_BELOW_RESET;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_STEREO_MODE:  stereo_ff <= csr_wdata[0];
            CSR_REFILL_BELOW: below_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      bytes_ff    <= bytes_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RESULT_W)'(0), rsp_data_ff};

endmodule

@@ design/abrff_chk.sv @@
// port-level checker for the audio byte ring frame feeder, bound to the top level
// depends on abrff_pkg

module abrff_chk
   import abrff_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [1:0]            req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  csr_wen,
   input logic [CSR_IDX_W-1:0]  csr_addr,
   input logic [CSR_DATA_W-1:0] csr_wdata
);

   result_type rsp;
   assign rsp = result_type'(rsp_tdata[RESULT_W-1:0]);

   // a waiting response beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response beat dropped while stalled");

   // a frame is either delivered or an underrun, never both
   a_frame_xor: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp.frame_valid && rsp.underrun))
      else $error("frame_valid and underrun both set");

   // no delivered frame means silence
   a_silence: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp.frame_valid |-> rsp.left_sample == '0 && rsp.right_sample == '0)
      else $error("samples nonzero without a delivered frame");

   // overflow only reported with a full ring
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.overflow |-> rsp.fill_level == FILL_W'(RING_BYTES))
      else $error("overflow with ring not full");

   // a request taken with the response side idle yields a response straight from ST_DONE,
   // unless it is a pull
   a_short_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser != FUNC_PULL && !rsp_tvalid
      |-> ##2 rsp_tvalid)
      else $error("non-pull item did not answer in two cycles");

endmodule

bind audio_byte_ring_frame_feeder abrff_chk u_abrff_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_wen    (csr_wen),
   .csr_addr   (csr_addr),
   .csr_wdata  (csr_wdata)
);
